[sv/dbcs_pkg.sv]
// ----------------------------------------------------------------------------
// dbcs_pkg
// Shared types and constants for the double-byte charset converter.
// ----------------------------------------------------------------------------
package dbcs_pkg;

   localparam int          CSR_AW    = 3;
   localparam int          CSR_DW    = 32;
   localparam logic        REG_MODE  = 1'b0;     // paddr[2] selects register
   localparam logic [7:0]  QMARK     = 8'h3F;
   localparam logic [7:0]  LEAD_BASE = 8'h80;
   localparam logic        KIND_WRITE = 1'b0;

   // what one accepted beat turns into on the output side
   typedef enum logic [2:0] {
      RES_NONE,
      RES_PASS,
      RES_WIDE,
      RES_TERM,
      RES_TERM_WIDE,
      RES_ABORT,
      RES_LOOKUP
   } res_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       send;
   } out_beat_type;

   typedef struct packed {
      logic [1:0]   count;
      out_beat_type beat0;
      out_beat_type beat1;
   } out_load_type;

endpackage

[sv/dbcs_req_if.sv]
// ----------------------------------------------------------------------------
// dbcs_req_if
// Input channel: table-write and text-byte beats.
// ----------------------------------------------------------------------------
interface dbcs_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  text_byte;
   logic [1:0]  table_id;
   logic [6:0]  lead_row;
   logic [7:0]  trail_col;
   logic [15:0] table_word;

   modport source (
      output valid, kind, text_byte, table_id, lead_row, trail_col, table_word,
      input  ready
   );
   modport sink (
      input  valid, kind, text_byte, table_id, lead_row, trail_col, table_word,
      output ready
   );
endinterface

[sv/dbcs_rsp_if.sv]
// ----------------------------------------------------------------------------
// dbcs_rsp_if
// Result channel: converted output bytes.
// ----------------------------------------------------------------------------
interface dbcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       string_end;

   modport source (
      output valid, out_byte, last_of_run, string_end,
      input  ready
   );
   modport sink (
      input  valid, out_byte, last_of_run, string_end,
      output ready
   );
endinterface

[sv/dbcs_table_mem.sv]
// ----------------------------------------------------------------------------
// dbcs_table_mem
// Code table store, one write and one registered read port, with a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module dbcs_table_mem #(
   parameter int DEPTH = 131072,
   parameter int AW    = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data,
   output logic          clr_busy
);
   import dbcs_pkg::*;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [15:0]   mem [DEPTH];
   logic [15:0]   rd_data_ff;
   logic          busy_ff, busy_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0]   mem_wd;

   always_comb begin
      busy_in = busy_ff;
      ptr_in  = ptr_ff;
      if (busy_ff) begin
         if (ptr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
      mem_we = busy_ff | wr_en;
      mem_wa = busy_ff ? ptr_ff : wr_addr;
      mem_wd = busy_ff ? 16'h0000 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         ptr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ptr_ff  <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = busy_ff;

endmodule

[sv/dbcs_out_buf.sv]
// ----------------------------------------------------------------------------
// dbcs_out_buf
// Two-entry output buffer; drains one byte per beat onto the result channel.
// ----------------------------------------------------------------------------
module dbcs_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  dbcs_pkg::out_load_type load,
   output logic                  load_ready,
   dbcs_rsp_if.source            rsp_chan
);
   import dbcs_pkg::*;

   out_beat_type ent0_ff, ent0_in;
   out_beat_type ent1_ff, ent1_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         fire;
   logic         do_load;

   always_comb begin
      fire       = (cnt_ff != 2'd0) & rsp_chan.ready;
      load_ready = (cnt_ff == 2'd0) | ((cnt_ff == 2'd1) & rsp_chan.ready);
      do_load    = load_valid & load_ready;
      ent0_in    = ent0_ff;
      ent1_in    = ent1_ff;
      cnt_in     = cnt_ff;
      if (do_load) begin
         ent0_in = load.beat0;
         ent1_in = load.beat1;
         cnt_in  = load.count;
      end else if (fire) begin
         ent0_in = ent1_ff;
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.out_byte    = ent0_ff.data;
   assign rsp_chan.last_of_run = ent0_ff.last;
   assign rsp_chan.string_end  = ent0_ff.send;

endmodule

[sv/dbcs_charset_converter.sv]
// ----------------------------------------------------------------------------
// dbcs_charset_converter
// Big5 / GBK / UTF-16LE converter driven by four loadable code tables.
// ----------------------------------------------------------------------------
//  channel    dir   beat carries
//  req_chan   in    kind, text_byte, table_id, lead_row, trail_col, table_word
//  rsp_chan   out   out_byte, last_of_run, string_end
//  csr_*      in    APB, one register: mode at 0x0
//
//  Rate: a table write, lead byte, ASCII byte (narrow modes) or narrow
//  terminator is taken back to back while rsp_chan is ready; an item giving
//  two bytes is paced by the output buffer draining one byte per cycle. The
//  first byte passes the table read (stage 1), then the buffer load.
//  Reset: the table store is swept to zero, one word per cycle, over all DEPTH
//  words (131072 at defaults); req_chan.ready stays low meanwhile.
//  Stalls: a buffer not free for a load holds stage 1, which then holds req_chan.ready.
// ----------------------------------------------------------------------------
module dbcs_charset_converter #(
   parameter int LEAD_ROWS   = 128,
   parameter int TRAIL_COLS  = 256,
   parameter int TABLE_COUNT = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   dbcs_req_if.sink                      req_chan,
   dbcs_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dbcs_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dbcs_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dbcs_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import dbcs_pkg::*;

   localparam int DEPTH = TABLE_COUNT * LEAD_ROWS * TRAIL_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ---- config register ----
   logic [1:0] mode_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_MODE) ? {{(CSR_DW-2){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
      end else if (csr_wr && csr_paddr[2] == REG_MODE) begin
         mode_ff <= csr_pwdata[1:0];
      end
   end

   // ---- accept stage: decode, lead tracking, table access ----
   logic          lead_pending_ff, lead_pending_in;
   logic [6:0]    held_lead_ff, held_lead_in;
   logic          accept;
   logic          unicode;
   res_type       res_in;
   logic          wr_hit;
   logic          rd_hit;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;
   logic          clr_busy;

   // stage 1
   logic          s1_valid_ff, s1_valid_in;
   res_type       s1_res_ff;
   logic [7:0]    s1_byte_ff;
   logic          s1_hit_ff;
   logic          s1_done;
   logic          load_valid;
   logic          load_ready;
   out_load_type  load;
   logic [15:0]   word;

   assign unicode = mode_ff[1];
   assign accept  = req_chan.valid & req_chan.ready;
   assign req_chan.ready = ~clr_busy & (~s1_valid_ff | s1_done);

   // table write: drop anything outside the configured geometry
   assign wr_hit = (32'(req_chan.table_id) < TABLE_COUNT)
                 & (32'(req_chan.lead_row) < LEAD_ROWS)
                 & (32'(req_chan.trail_col) < TRAIL_COLS);
   assign wr_addr = AW'((AW'(req_chan.table_id) * AW'(LEAD_ROWS) + AW'(req_chan.lead_row))
                        * AW'(TRAIL_COLS) + AW'(req_chan.trail_col));

   // trail lookup uses mode and the held row; out of range reads as zero
   assign rd_hit = (32'(mode_ff) < TABLE_COUNT)
                 & (32'(held_lead_ff) < LEAD_ROWS)
                 & (32'(req_chan.text_byte) < TRAIL_COLS);
   assign rd_addr = AW'((AW'(mode_ff) * AW'(LEAD_ROWS) + AW'(held_lead_ff))
                        * AW'(TRAIL_COLS) + AW'(req_chan.text_byte));

   always_comb begin
      res_in          = RES_NONE;
      lead_pending_in = lead_pending_ff;
      held_lead_in    = held_lead_ff;
      if (req_chan.kind != KIND_WRITE) begin
         if (lead_pending_ff) begin
            lead_pending_in = 1'b0;
            res_in = (req_chan.text_byte == 8'h00) ? RES_ABORT : RES_LOOKUP;
         end else if (req_chan.text_byte == 8'h00) begin
            res_in = unicode ? RES_TERM_WIDE : RES_TERM;
         end else if (req_chan.text_byte < LEAD_BASE) begin
            res_in = unicode ? RES_WIDE : RES_PASS;
         end else begin
            lead_pending_in = 1'b1;
            held_lead_in    = req_chan.text_byte[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         held_lead_ff    <= 7'd0;
      end else if (accept) begin
         lead_pending_ff <= lead_pending_in;
         held_lead_ff    <= held_lead_in;
      end
   end

   dbcs_table_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept & (req_chan.kind == KIND_WRITE) & wr_hit),
      .wr_addr  (wr_addr),
      .wr_data  (req_chan.table_word),
      .rd_en    (accept & (req_chan.kind != KIND_WRITE)),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clr_busy (clr_busy)
   );

   // ---- stage 1: table word arrives, build up to two output beats ----
   assign load_valid = s1_valid_ff & (s1_res_ff != RES_NONE);
   assign s1_done    = s1_valid_ff & ((s1_res_ff == RES_NONE) | load_ready);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff  <= res_in;
         s1_byte_ff <= req_chan.text_byte;
         s1_hit_ff  <= rd_hit;
      end
   end

   always_comb begin
      word = s1_hit_ff ? rd_data : 16'h0000;
      load = '0;
      case (s1_res_ff)
         RES_PASS: begin
            load.count = 2'd1;
            load.beat0 = '{data: s1_byte_ff, last: 1'b1, send: 1'b0};
         end
         RES_WIDE: begin
            load.count = 2'd2;
            load.beat0 = '{data: s1_byte_ff, last: 1'b0, send: 1'b0};
            load.beat1 = '{data: 8'h00, last: 1'b1, send: 1'b0};
         end
         RES_TERM: begin
            load.count = 2'd1;
            load.beat0 = '{data: 8'h00, last: 1'b1, send: 1'b1};
         end
         RES_TERM_WIDE: begin
            load.count = 2'd2;
            load.beat0 = '{data: 8'h00, last: 1'b0, send: 1'b1};
            load.beat1 = '{data: 8'h00, last: 1'b1, send: 1'b1};
         end
         RES_ABORT: begin
            // lead byte cut off by NUL
            load.count = 2'd2;
            load.beat0 = '{data: QMARK, last: 1'b0, send: 1'b1};
            load.beat1 = '{data: 8'h00, last: 1'b1, send: 1'b1};
         end
         RES_LOOKUP: begin
            load.count = 2'd2;
            if (word != 16'h0000) begin
               load.beat0 = '{data: word[7:0], last: 1'b0, send: 1'b0};
               load.beat1 = '{data: word[15:8], last: 1'b1, send: 1'b0};
            end else begin
               // unmapped pair
               load.beat0 = '{data: QMARK, last: 1'b0, send: 1'b0};
               load.beat1 = '{data: QMARK, last: 1'b1, send: 1'b0};
            end
         end
         default: begin
            load = '0;
         end
      endcase
   end

   dbcs_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load       (load),
      .load_ready (load_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

[tb/sv/dbcs_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_tb_pkg
// Beat types and the output-byte scoreboard for the charset converter bench.
// ----------------------------------------------------------------------------
package dbcs_tb_pkg;

   localparam bit KIND_TEXT = 1'b1;

   // conversion mode; also the table a lookup reads in that mode
   typedef enum bit [1:0] {
      MODE_BIG5_GBK,
      MODE_GBK_BIG5,
      MODE_BIG5_UNI,
      MODE_GBK_UNI
   } conv_mode_type;

   typedef struct packed {
      bit        kind;
      bit [7:0]  text_byte;
      bit [1:0]  table_id;
      bit [6:0]  lead_row;
      bit [7:0]  trail_col;
      bit [15:0] table_word;
   } req_item_type;

   typedef struct packed {
      bit [7:0] data;
      bit       last;
      bit       term;
   } out_byte_type;

   class dbcs_output_scoreboard;
      bit [15:0]     code_words [0:131071];   // {table, row, col}
      conv_mode_type mode;
      bit            lead_pending;
      bit [6:0]      held_lead;
      out_byte_type  due_bytes [$];
      int            errors;
      int            table_writes;
      int            text_bytes;
      int            hits;
      int            misses;
      int            string_ends;
      int            broken_pairs;
      int            bytes_checked;

      function void set_mode(conv_mode_type m);
         mode = m;
      endfunction

      function int pending_count();
         return due_bytes.size();
      endfunction

      function void push_byte(bit [7:0] data, bit last, bit term);
         out_byte_type e;
         e.data = data;
         e.last = last;
         e.term = term;
         due_bytes.push_back(e);
      endfunction

      // works out the bytes one accepted beat produces
      function void convert_item(req_item_type it);
         bit [15:0] w;
         bit        wide;
         wide = (mode == MODE_BIG5_UNI) || (mode == MODE_GBK_UNI);
         if (it.kind == dbcs_pkg::KIND_WRITE) begin
            code_words[{it.table_id, it.lead_row, it.trail_col}] = it.table_word;
            table_writes++;
            return;
         end
         text_bytes++;
         if (lead_pending) begin
            lead_pending = 1'b0;
            if (it.text_byte == 8'h00) begin
               push_byte(dbcs_pkg::QMARK, 1'b0, 1'b1);
               push_byte(8'h00, 1'b1, 1'b1);
               broken_pairs++;
            end else begin
               w = code_words[{mode, held_lead, it.text_byte}];
               if (w != 16'h0000) begin
                  push_byte(w[7:0], 1'b0, 1'b0);
                  push_byte(w[15:8], 1'b1, 1'b0);
                  hits++;
               end else begin
                  push_byte(dbcs_pkg::QMARK, 1'b0, 1'b0);
                  push_byte(dbcs_pkg::QMARK, 1'b1, 1'b0);
                  misses++;
               end
            end
         end else if (it.text_byte == 8'h00) begin
            string_ends++;
            if (wide) begin
               push_byte(8'h00, 1'b0, 1'b1);
               push_byte(8'h00, 1'b1, 1'b1);
            end else begin
               push_byte(8'h00, 1'b1, 1'b1);
            end
         end else if (it.text_byte < dbcs_pkg::LEAD_BASE) begin
            if (wide) begin
               push_byte(it.text_byte, 1'b0, 1'b0);
               push_byte(8'h00, 1'b1, 1'b0);
            end else begin
               push_byte(it.text_byte, 1'b1, 1'b0);
            end
         end else begin
            lead_pending = 1'b1;
            held_lead    = it.text_byte[6:0];
         end
      endfunction

      function void check_out_byte(logic [7:0] data, logic last, logic term);
         out_byte_type e;
         bytes_checked++;
         if (due_bytes.size() == 0) begin
            $error("unexpected output byte 0x%02h", data);
            errors++;
            return;
         end
         e = due_bytes.pop_front();
         if (data !== e.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", e.data, data);
            errors++;
         end
         if (last !== e.last) begin
            $error("last_of_run: expected %0b, actual %0b", e.last, last);
            errors++;
         end
         if (term !== e.term) begin
            $error("string_end: expected %0b, actual %0b", e.term, term);
            errors++;
         end
      endfunction
   endclass

endpackage

[tb/sv/dbcs_charset_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_charset_converter_test
// Self-checking bench for the Big5 / GBK / UTF-16LE converter. Loads code
// words, streams text in all four modes with random gaps and stalls on both
// channels, and checks every output byte against a local predictor.
// ----------------------------------------------------------------------------
module dbcs_charset_converter_test;
   import dbcs_pkg::*;
   import dbcs_tb_pkg::*;

   localparam logic [CSR_AW-1:0] MODE_ADDR = {REG_MODE, 2'b00};
   localparam int IDLE_PCT     = 34;          // chance of a gap / stall per cycle
   localparam int PHASE_ITEMS  = 150;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 8;           // settle time after the last due byte; plenty of margin
   localparam int TIMEOUT_NS   = 10_000_000;  // reset sweep alone is ~1.6 ms

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   bit                    steady;   // no gaps or stalls on either side
   dbcs_output_scoreboard sb;

   dbcs_req_if req_if ();
   dbcs_rsp_if rsp_if ();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   dbcs_charset_converter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------
   // result side: random stalls, every accepted beat goes to the scoreboard
   // ---------------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready)
            sb.check_out_byte(rsp_if.out_byte, rsp_if.last_of_run, rsp_if.string_end);
      end
   end

   // hard stop if the block hangs
   initial begin
      #TIMEOUT_NS;
      $display("timeout with %0d output bytes still due", sb.pending_count());
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // drive tasks: entered at a falling edge, return at a falling edge
   // ---------------------------------------------------------------------

   // one beat on req_chan, with random gaps ahead of it
   task automatic send_beat(req_item_type it);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.kind       <= it.kind;
      req_if.text_byte  <= it.text_byte;
      req_if.table_id   <= it.table_id;
      req_if.lead_row   <= it.lead_row;
      req_if.trail_col  <= it.trail_col;
      req_if.table_word <= it.table_word;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.convert_item(it);
      @(negedge clock);
   endtask

   // text beat; the table fields are don't-care and get random values
   task automatic send_text(bit [7:0] b);
      req_item_type it;
      it.kind       = KIND_TEXT;
      it.text_byte  = b;
      it.table_id   = 2'($urandom);
      it.lead_row   = 7'($urandom);
      it.trail_col  = 8'($urandom);
      it.table_word = 16'($urandom);
      send_beat(it);
   endtask

   task automatic send_table_write(bit [1:0] t, bit [6:0] r, bit [7:0] c, bit [15:0] w);
      req_item_type it;
      it.kind       = KIND_WRITE;
      it.text_byte  = 8'($urandom);
      it.table_id   = t;
      it.lead_row   = r;
      it.trail_col  = c;
      it.table_word = w;
      send_beat(it);
   endtask

   // lead byte for the given row, then the trail byte
   task automatic send_pair(bit [6:0] row, bit [7:0] trail);
      send_text(LEAD_BASE | row);
      send_text(trail);
   endtask

   // stop sending, wait for every due byte, then let the pipe settle
   task automatic drain(int extra);
      req_if.valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   // APB write of the mode register, only with the block idle
   task automatic write_mode(conv_mode_type m);
      drain(DRAIN_CYCLES);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= CSR_DW'(m);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.set_mode(m);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Load a few words into this mode's table, then a mix that is mostly
   // double-byte characters that hit them, plus ASCII, misses, string ends,
   // broken pairs, stray table writes and raw noise.
   task automatic run_random_phase(conv_mode_type m, int n_items);
      bit [6:0]  rows [4];
      bit [6:0]  hit_rows [$];
      bit [7:0]  hit_cols [$];
      bit [15:0] w;
      bit        paused;
      int        sent;
      int        pick;
      int        k;
      write_mode(m);
      rows = '{7'd0, 7'd127, 7'($urandom), 7'($urandom)};
      for (k = 0; k < 16; k++) begin
         if ($urandom_range(7) == 0)      w = 16'h0000;   // unmapped entry
         else if ($urandom_range(7) == 0) w = 16'hFFFF;
         else                             w = 16'($urandom);
         hit_rows.push_back(rows[$urandom_range(3)]);
         hit_cols.push_back(8'($urandom_range(255, 1)));
         send_table_write(m, hit_rows[k], hit_cols[k], w);
      end
      sent   = 16;
      paused = 1'b0;
      while (sent < n_items) begin
         // hold the sender until the output side has fully caught up
         if (!paused && sent >= n_items / 2) begin
            drain(0);
            paused = 1'b1;
         end
         k    = $urandom_range(hit_rows.size() - 1);
         pick = $urandom_range(99);
         if (pick < 50) begin
            send_pair(hit_rows[k], hit_cols[k]);
            sent += 2;
         end else if (pick < 62) begin
            send_text(8'($urandom_range(127, 1)));
            sent++;
         end else if (pick < 72) begin
            send_pair(7'($urandom), 8'($urandom_range(255, 1)));
            sent += 2;
         end else if (pick < 77) begin
            send_text(8'h00);
            sent++;
         end else if (pick < 80) begin
            send_pair(7'($urandom), 8'h00);
            sent += 2;
         end else if (pick < 87) begin
            send_table_write(2'($urandom), 7'($urandom), 8'($urandom), 16'($urandom));
            sent++;
         end else if (pick < 93) begin
            send_text(8'($urandom));
            sent++;
         end else begin
            // table write slipped in while a lead byte is held
            send_text(LEAD_BASE | hit_rows[k]);
            send_table_write(2'($urandom), 7'($urandom), 8'($urandom), 16'($urandom));
            send_text(hit_cols[k]);
            sent += 3;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      conv_mode_type phase_modes [PHASES];
      conv_mode_type m;
      int            i;

      sb = new();
      req_if.valid      = 1'b0;
      req_if.kind       = KIND_WRITE;
      req_if.text_byte  = '0;
      req_if.table_id   = '0;
      req_if.lead_row   = '0;
      req_if.trail_col  = '0;
      req_if.table_word = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      steady            = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: narrow mode first
      // (req_chan stays stalled through the table clear; send_beat waits it out)
      write_mode(MODE_BIG5_GBK);
      send_table_write(MODE_BIG5_GBK, 7'd0, 8'h40, 16'h1234);
      send_table_write(MODE_BIG5_GBK, 7'd127, 8'hFF, 16'hFFFF);
      send_table_write(MODE_BIG5_GBK, 7'd1, 8'h01, 16'h0100);   // zero low byte
      send_table_write(MODE_BIG5_UNI, 7'd0, 8'h40, 16'hABCD);
      send_text(8'h41);
      send_text(8'h01);
      send_text(8'h7F);
      send_pair(7'd0, 8'h40);
      send_pair(7'd127, 8'hFF);
      send_pair(7'd1, 8'h01);
      send_pair(7'd5, 8'h80);        // never written: question marks
      send_text(LEAD_BASE);          // lead held across a table write
      send_table_write(MODE_BIG5_GBK, 7'd0, 8'h41, 16'h5678);
      send_text(8'h41);
      send_pair(7'd0, 8'h00);        // NUL right after a lead
      send_text(8'h00);              // plain terminator

      // directed: wide mode
      write_mode(MODE_BIG5_UNI);
      send_text(8'h41);
      send_pair(7'd0, 8'h40);
      send_pair(7'd0, 8'h00);
      send_text(8'h00);

      // random phases; both extremes of mode are in the fixed part of the list
      phase_modes = '{MODE_GBK_UNI, MODE_GBK_BIG5, MODE_BIG5_GBK, MODE_BIG5_UNI,
                      MODE_GBK_UNI, MODE_BIG5_GBK, MODE_BIG5_GBK, MODE_BIG5_GBK};
      for (i = 0; i < PHASES; i++) begin
         m = (i >= 6) ? conv_mode_type'($urandom_range(3)) : phase_modes[i];
         steady = (i == 2);          // one phase with no gaps at all
         run_random_phase(m, PHASE_ITEMS);
      end
      steady = 1'b0;

      drain(DRAIN_CYCLES * 4);

      $display("Ran %0d table writes and %0d text bytes across all four modes:",
               sb.table_writes, sb.text_bytes);
      $display("%0d hits, %0d misses, %0d string ends, %0d broken pairs, %0d bytes compared.",
               sb.hits, sb.misses, sb.string_ends, sb.broken_pairs, sb.bytes_checked);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
